>>> rtl/adsr_wavetable_noise_voice_core_defines.svh
// Assertion macros shared by the voice core checkers.
`ifndef ADSR_WAVETABLE_NOISE_VOICE_CORE_DEFINES_SVH
`define ADSR_WAVETABLE_NOISE_VOICE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet during reset.
`define AWNV_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and quiet during reset.
`define AWNV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/awnv_pkg.sv
// Types and constants of the ADSR wavetable noise voice.
package awnv_pkg;

  localparam int LEN_BITS     = 20;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 20;

  localparam logic [1:0] MODE_TICK     = 2'd0;
  localparam logic [1:0] MODE_NOTE_ON  = 2'd1;
  localparam logic [1:0] MODE_NOTE_OFF = 2'd2;
  localparam logic [1:0] MODE_TABLE_WR = 2'd3;

  localparam logic [CFG_IDX_BITS-1:0] CFG_ATTACK_LEN  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DECAY_LEN   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RELEASE_LEN = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SUSTAIN     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PEAK        = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_NOISE_MIX   = 3'd5;

  localparam logic [11:0] DAC_MIDDLE = 12'd2048;
  localparam logic [11:0] DAC_MAX    = 12'd4095;
  localparam logic [31:0] NOISE_SEED = 32'h1234_5678;
  localparam logic [15:0] PEAK_RESET = 16'd32768;

  typedef struct packed {
    logic [1:0]         mode;
    logic [23:0]        phase_step;
    logic [7:0]         table_index;
    logic signed [15:0] table_value;
  } awnv_in_t;

  typedef struct packed {
    logic [11:0] dac_code;
    logic        voice_active;
  } awnv_out_t;

  function automatic logic [31:0] xorshift32(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x << 13);
    y = y ^ (y >> 17);
    y = y ^ (y << 5);
    return y;
  endfunction

endpackage

>>> rtl/adsr_wavetable_noise_voice_core.sv
// Top level of the ADSR wavetable noise voice: sequencer, shared multiplier and divider.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_ready  | in_data  (mode, phase_step, table_index/value)
//  out     | out_valid/ out_ready | out_data (dac_code, voice_active)
//  cfg     | cfg_write            | cfg_index, cfg_data (no wait, no read-back)
//
// A note-on, note-off or table-write beat is taken in idle and gives no result.
// A tick beat forms the sustain product; an idle voice then goes to the output.
// A ramp stage divides its ramp product by the stage length, one quotient bit per
// cycle for 16 quotient bits. Unless a release ends, the wavetable read, the noise
// mix (if on), scaling and bias follow; one shared 34x21 multiplier does every product.
// Reset (rst, synchronous) returns the envelope to idle, reseeds the noise and
// loads the register defaults; the wavetable is not cleared.
// A finished result waits in the output register; the next beat is taken while
// it waits, and only a tick that finishes before the old result leaves stalls.
module adsr_wavetable_noise_voice_core
  import awnv_pkg::*;
#(
  parameter int TABLE_DEPTH         = 256,
  parameter int PHASE_FRACTION_BITS = 16,
  parameter int COUNT_BITS          = 20
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  awnv_in_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output awnv_out_t                out_data,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  // The table depth is taken to be a power of two, so the phase wraps by truncation.
  localparam int TB   = $clog2(TABLE_DEPTH);
  localparam int PW   = TB + PHASE_FRACTION_BITS;
  localparam int SW   = ((PW > 24) ? PW : 24) + 1;
  localparam int CMPW = ((COUNT_BITS > LEN_BITS) ? COUNT_BITS : LEN_BITS) + 1;
  localparam int QB   = 16;

  typedef enum logic [3:0] {
    S_IDLE, S_SUS, S_SUSW, S_ENV, S_DIVLD, S_DIV, S_ENVSET,
    S_RD, S_MIX1, S_MIX2, S_MIX3, S_SCALE, S_BIAS, S_OUT
  } seq_t;

  typedef enum logic [2:0] {
    EN_IDLE = 3'd0, EN_ATTACK = 3'd1, EN_DECAY = 3'd2, EN_SUSTAIN = 3'd3,
    EN_RELEASE = 3'd4
  } env_t;

  // Configuration registers.
  logic [LEN_BITS-1:0] attack_length, decay_length, release_length;
  logic [15:0]         sustain_level, peak_level, noise_mix;

  // Voice state.
  seq_t                  state;
  env_t                  stage;
  logic [COUNT_BITS-1:0] stage_count;
  logic [15:0]           level;
  logic [15:0]           release_start;
  logic [PW-1:0]         phase;
  logic [23:0]           phase_step;
  logic [31:0]           noise_state;

  // Datapath registers.
  logic [15:0]         sus;
  logic signed [54:0]  prod;
  logic [LEN_BITS-1:0] rem;
  logic [QB-1:0]       quo;
  logic [3:0]          div_cnt;
  logic signed [33:0]  s_acc;
  logic [48:0]         preg;
  awnv_out_t           out_q;

  // Wavetable.
  logic signed [15:0] wave_table [TABLE_DEPTH];
  logic signed [15:0] tone;

  logic               in_take;
  logic [LEN_BITS-1:0] len_raw, len_eff, pos, env_b;
  logic [15:0]         env_a;
  logic [CMPW-1:0]     count_ext, len_ext, cnt1;
  logic                stage_done;
  logic signed [33:0]  mul_a;
  logic signed [20:0]  mul_b;
  logic [LEN_BITS:0]   div_shift, div_diff;
  logic                div_bit;
  logic [SW-1:0]       phase_sum;
  logic signed [15:0]  noise_s;
  logic signed [54:0]  psum;
  logic [60:0]         vfull;
  logic [12:0]         vcode;

  assign in_ready = (state == S_IDLE);
  assign in_take  = in_valid && in_ready;
  assign out_data = out_q;

  // Length and ramp position of the current stage.
  always_comb begin
    case (stage)
      EN_ATTACK:  len_raw = attack_length;
      EN_DECAY:   len_raw = decay_length;
      EN_RELEASE: len_raw = release_length;
      default:    len_raw = attack_length;
    endcase
    len_eff    = (len_raw == '0) ? LEN_BITS'(1) : len_raw;
    count_ext  = CMPW'(stage_count);
    len_ext    = CMPW'(len_eff);
    cnt1       = count_ext + CMPW'(1);
    stage_done = (cnt1 >= len_ext);
    pos        = (count_ext < len_ext) ? count_ext[LEN_BITS-1:0] : len_eff;
    case (stage)
      EN_DECAY: begin
        env_a = peak_level - sus;
        env_b = pos;
      end
      EN_RELEASE: begin
        env_a = release_start;
        env_b = len_eff - pos;
      end
      default: begin
        env_a = peak_level;
        env_b = pos;
      end
    endcase
  end

  // Operand selection for the shared multiplier.
  assign noise_s = signed'(noise_state[15:0] ^ 16'h8000);

  always_comb begin
    case (state)
      S_SUS: begin
        mul_a = 34'(peak_level);
        mul_b = 21'(sustain_level);
      end
      S_ENV: begin
        mul_a = 34'(env_a);
        mul_b = 21'(env_b);
      end
      S_MIX1: begin
        mul_a = 34'(noise_s);
        mul_b = 21'(noise_mix);
      end
      S_MIX2: begin
        mul_a = 34'(tone);
        mul_b = 21'(17'h10000 - 17'(noise_mix));
      end
      S_SCALE: begin
        mul_a = s_acc;
        mul_b = 21'(level);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // One restoring division step, one quotient bit per cycle.
  assign div_shift = {rem, quo[QB-1]};
  assign div_diff  = div_shift - {1'b0, len_eff};
  assign div_bit   = (div_shift >= {1'b0, len_eff});

  assign phase_sum = SW'(phase) + SW'(phase_step);
  assign psum      = prod + (55'sd1 <<< 47);
  assign vfull     = {preg, 12'b0} - 61'(preg);
  assign vcode     = vfull[60:48];

  // Wavetable: written by table-write beats, read with a registered port.
  always_ff @(posedge clk) begin
    if (in_take && in_data.mode == MODE_TABLE_WR) begin
      wave_table[TB'(in_data.table_index)] <= in_data.table_value;
    end
    if (state == S_RD) begin
      tone <= wave_table[phase[PW-1 -: TB]];
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      state          <= S_IDLE;
      stage          <= EN_IDLE;
      stage_count    <= '0;
      level          <= '0;
      release_start  <= '0;
      phase          <= '0;
      phase_step     <= '0;
      noise_state    <= NOISE_SEED;
      out_valid      <= 1'b0;
      attack_length  <= LEN_BITS'(1);
      decay_length   <= LEN_BITS'(1);
      release_length <= LEN_BITS'(1);
      sustain_level  <= '0;
      peak_level     <= PEAK_RESET;
      noise_mix      <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_ATTACK_LEN:  attack_length  <= cfg_data;
          CFG_DECAY_LEN:   decay_length   <= cfg_data;
          CFG_RELEASE_LEN: release_length <= cfg_data;
          CFG_SUSTAIN:     sustain_level  <= cfg_data[15:0];
          CFG_PEAK:        peak_level     <= cfg_data[15:0];
          CFG_NOISE_MIX:   noise_mix      <= cfg_data[15:0];
          default: ;
        endcase
      end
      // The output stage reloads the register itself when it finishes a tick.
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_take) begin
            case (in_data.mode)
              MODE_TICK: state <= S_SUS;
              MODE_NOTE_ON: begin
                phase_step  <= in_data.phase_step;
                phase       <= '0;
                stage_count <= '0;
                stage       <= EN_ATTACK;
              end
              MODE_NOTE_OFF: begin
                if (stage == EN_ATTACK || stage == EN_DECAY || stage == EN_SUSTAIN) begin
                  release_start <= level;
                  stage_count   <= '0;
                  stage         <= EN_RELEASE;
                end
              end
              default: ;
            endcase
          end
        end
        S_SUS: state <= S_SUSW;
        S_SUSW: begin
          sus <= prod[31:16];
          if (stage == EN_ATTACK || stage == EN_DECAY || stage == EN_RELEASE) begin
            state <= S_ENV;
          end else begin
            state <= S_ENVSET;
          end
        end
        S_ENV: state <= S_DIVLD;
        S_DIVLD: begin
          rem     <= prod[35:16];
          quo     <= prod[15:0];
          div_cnt <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          rem     <= div_bit ? div_diff[LEN_BITS-1:0] : div_shift[LEN_BITS-1:0];
          quo     <= {quo[QB-2:0], div_bit};
          div_cnt <= div_cnt + 4'd1;
          if (div_cnt == 4'(QB - 1)) begin
            state <= S_ENVSET;
          end
        end
        S_ENVSET: begin
          case (stage)
            EN_ATTACK: begin
              level <= quo;
              state <= S_RD;
              if (stage_done) begin
                stage_count <= '0;
                stage       <= EN_DECAY;
              end else begin
                stage_count <= cnt1[COUNT_BITS-1:0];
              end
            end
            EN_DECAY: begin
              level <= peak_level - quo;
              state <= S_RD;
              if (stage_done) begin
                stage_count <= '0;
                stage       <= EN_SUSTAIN;
              end else begin
                stage_count <= cnt1[COUNT_BITS-1:0];
              end
            end
            EN_SUSTAIN: begin
              level <= sus;
              state <= S_RD;
            end
            EN_RELEASE: begin
              if (stage_done || quo == '0) begin
                level       <= '0;
                stage_count <= '0;
                stage       <= EN_IDLE;
                state       <= S_OUT;
              end else begin
                level       <= quo;
                stage_count <= cnt1[COUNT_BITS-1:0];
                state       <= S_RD;
              end
            end
            default: begin
              level <= '0;
              stage <= EN_IDLE;
              state <= S_OUT;
            end
          endcase
        end
        S_RD: begin
          phase <= phase_sum[PW-1:0];
          if (noise_mix != '0) begin
            noise_state <= xorshift32(noise_state);
          end
          state <= S_MIX1;
        end
        S_MIX1: begin
          if (noise_mix == '0) begin
            s_acc <= {{2{tone[15]}}, tone, 16'b0};
            state <= S_SCALE;
          end else begin
            state <= S_MIX2;
          end
        end
        S_MIX2: begin
          s_acc <= prod[33:0];
          state <= S_MIX3;
        end
        S_MIX3: begin
          s_acc <= s_acc + prod[33:0];
          state <= S_SCALE;
        end
        S_SCALE: state <= S_BIAS;
        S_BIAS: begin
          preg  <= psum[54] ? '0 : psum[48:0];
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid          <= 1'b1;
            out_q.voice_active <= (stage != EN_IDLE);
            if (stage == EN_IDLE) begin
              out_q.dac_code <= DAC_MIDDLE;
            end else begin
              out_q.dac_code <= (vcode > 13'(DAC_MAX)) ? DAC_MAX : vcode[11:0];
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/awnv_checker.sv
// Port-level checker for the voice core and its bind.
`include "adsr_wavetable_noise_voice_core_defines.svh"
module awnv_checker
  import awnv_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input awnv_in_t                 in_data,
  input logic                     out_valid,
  input logic                     out_ready,
  input awnv_out_t                out_data,
  input logic                     cfg_write,
  input logic [CFG_IDX_BITS-1:0]  cfg_index,
  input logic [CFG_DATA_BITS-1:0] cfg_data
);

  `AWNV_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped")
  `AWNV_ASSERT_NEXT(a_tick_busy, in_valid && in_ready && in_data.mode == MODE_TICK, !in_ready, "tick not held busy")
  `AWNV_ASSERT_SAME(a_idle_mid, out_valid && !out_data.voice_active, out_data.dac_code == DAC_MIDDLE, "idle voice not mid-scale")
  `AWNV_ASSERT_NEXT(a_ctl_silent, in_valid && in_ready && in_data.mode != MODE_TICK && !out_valid, !out_valid, "control beat gave a result")

endmodule

bind adsr_wavetable_noise_voice_core awnv_checker u_awnv_checker (.*);

>>> test/tb_adsr_wavetable_noise_voice_core.sv
// Self-checking testbench for the ADSR wavetable noise voice core.
`default_nettype none

module tb_adsr_wavetable_noise_voice_core;
  import awnv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Envelope stages of the local voice predictor.
  typedef enum int {STG_IDLE, STG_ATTACK, STG_DECAY, STG_SUSTAIN, STG_RELEASE} stage_e;

  localparam longint PHASE_MOD   = longint'(256) << 16;
  localparam longint COUNT_MASK  = (longint'(1) << 20) - 1;
  localparam int     STALL_MAX   = 13;
  // Margin after the queue drains; leave generous room for the longest ramp tick.
  localparam int     DRAIN_CYCLES = 60;
  localparam int     HANG_LIMIT   = 5000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  awnv_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  awnv_out_t out_data;
  logic      cfg_write = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  adsr_wavetable_noise_voice_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Beats waiting to be sent, and DAC results the voice still owes us.
  awnv_in_t  note_queue[$];
  awnv_out_t dac_expected[$];
  int        errors = 0;
  bit        quiet = 1'b0;   // when set, neither side inserts gaps
  bit        in_took = 1'b0;
  bit        out_took = 1'b0;

  // Predictor copy of the registers and of the voice state.
  longint attack_len = 1, decay_len = 1, release_len = 1;
  longint sustain_frac = 0, peak = 32768, noise_share = 0;
  stage_e stage = STG_IDLE;
  longint ramp_count = 0, level = 0, release_from = 0;
  longint phase = 0, step = 0;
  logic [31:0] lfsr = NOISE_SEED;
  logic signed [15:0] wave[256];

  function automatic longint eff_len(longint len);
    return (len == 0) ? 1 : len;
  endfunction

  // Bumps the ramp counter; returns 1 when the stage has run its length.
  function automatic bit ramp_done(longint len);
    longint nxt;
    nxt = ramp_count + 1;
    if (nxt >= len) begin
      ramp_count = 0;
      return 1'b1;
    end
    ramp_count = nxt & COUNT_MASK;
    return 1'b0;
  endfunction

  // One sample tick of the voice: envelope step, oscillator, noise, DAC scaling.
  function automatic awnv_out_t voice_tick();
    longint sus, len, pos, tone, noise, s, p, v;
    awnv_out_t r;
    sus = (peak * sustain_frac) >> 16;
    case (stage)
      STG_ATTACK: begin
        len = eff_len(attack_len);
        pos = (ramp_count < len) ? ramp_count : len;
        level = (peak * pos) / len;
        if (ramp_done(len)) stage = STG_DECAY;
      end
      STG_DECAY: begin
        len = eff_len(decay_len);
        pos = (ramp_count < len) ? ramp_count : len;
        level = peak - ((peak - sus) * pos) / len;
        if (ramp_done(len)) stage = STG_SUSTAIN;
      end
      STG_SUSTAIN: level = sus;
      STG_RELEASE: begin
        len = eff_len(release_len);
        pos = (ramp_count < len) ? ramp_count : len;
        level = (release_from * (len - pos)) / len;
        if (ramp_done(len) || level == 0) begin
          level = 0;
          ramp_count = 0;
          stage = STG_IDLE;
        end
      end
      default: begin
        stage = STG_IDLE;
        level = 0;
      end
    endcase
    r.dac_code = DAC_MIDDLE;
    if (stage != STG_IDLE) begin
      tone = wave[(phase >> 16) % 256];
      phase = (phase % PHASE_MOD + step) % PHASE_MOD;
      if (noise_share != 0) begin
        lfsr = lfsr ^ (lfsr << 13);
        lfsr = lfsr ^ (lfsr >> 17);
        lfsr = lfsr ^ (lfsr << 5);
        noise = longint'(lfsr[15:0]) - 32768;
        s = noise_share * noise + (65536 - noise_share) * tone;
      end else begin
        s = tone * 65536;
      end
      p = s * level + (longint'(1) << 47);
      if (p < 0) p = 0;
      v = (p * 4095) >> 48;
      r.dac_code = (v > 4095) ? DAC_MAX : v[11:0];
    end
    r.voice_active = (stage != STG_IDLE);
    return r;
  endfunction

  // Applies one accepted beat to the predictor; ticks queue an expected result.
  task automatic predict_beat(awnv_in_t b);
    case (b.mode)
      MODE_NOTE_ON: begin
        step = b.phase_step;
        phase = 0;
        ramp_count = 0;
        stage = STG_ATTACK;
      end
      MODE_NOTE_OFF: begin
        if (stage != STG_IDLE && stage != STG_RELEASE) begin
          release_from = level;
          ramp_count = 0;
          stage = STG_RELEASE;
        end
      end
      MODE_TABLE_WR: wave[b.table_index] = b.table_value;
      default: dac_expected.push_back(voice_tick());
    endcase
  endtask

  // Monitor: predicts on every input beat, checks every output beat, and
  // watches for a stalled pipeline.
  int idle_cycles = 0;
  always @(posedge clk) begin
    awnv_out_t exp_r;
    in_took  <= in_valid && in_ready;
    out_took <= out_valid && out_ready;
    if (!rst) begin
      if (in_valid && in_ready) predict_beat(in_data);
      if (out_valid && out_ready) begin
        if (dac_expected.size() == 0) begin
          $display("%0t: unexpected beat dac_code=%0d voice_active=%0b",
                   $time, out_data.dac_code, out_data.voice_active);
          errors++;
        end else begin
          exp_r = dac_expected.pop_front();
          if (out_data.dac_code !== exp_r.dac_code) begin
            $display("%0t: dac_code expected %0d actual %0d",
                     $time, exp_r.dac_code, out_data.dac_code);
            errors++;
          end
          if (out_data.voice_active !== exp_r.voice_active) begin
            $display("%0t: voice_active expected %0b actual %0b",
                     $time, exp_r.voice_active, out_data.voice_active);
            errors++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Input driver: holds a beat until it is taken, then waits a random gap.
  int in_gap = 0;
  always @(negedge clk) begin
    if (!rst && (!in_valid || in_took)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (note_queue.size() > 0) begin
        in_data <= note_queue.pop_front();
        in_valid <= 1'b1;
        in_gap <= quiet ? 0 : $urandom_range(0, STALL_MAX);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output side: a fresh stall length for every result taken.
  int out_stall = 0;
  always @(negedge clk) begin
    int st;
    st = out_stall;
    if (out_took) st = quiet ? 0 : $urandom_range(0, STALL_MAX);
    if (st > 0) begin
      out_ready <= 1'b0;
      out_stall <= st - 1;
    end else begin
      out_ready <= !rst;
      out_stall <= 0;
    end
  end

  function automatic awnv_in_t make_beat(logic [1:0] m, logic [23:0] ps,
                                         logic [7:0] ti, logic [15:0] tv);
    awnv_in_t b;
    b.mode = m;
    b.phase_step = ps;
    b.table_index = ti;
    b.table_value = tv;
    return b;
  endfunction

  task automatic push(logic [1:0] m, logic [23:0] ps = '0, logic [7:0] ti = '0,
                      logic [15:0] tv = '0);
    note_queue.push_back(make_beat(m, ps, ti, tv));
  endtask

  task automatic ticks(int n);
    repeat (n) push(MODE_TICK, 24'($urandom), 8'($urandom), 16'($urandom));
  endtask

  // Waits until the voice has nothing in flight, so registers may change.
  task automatic settle();
    while (note_queue.size() > 0 || in_valid || dac_expected.size() > 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_BITS-1:0] idx, int unsigned val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_BITS-1:0];
    case (idx)
      CFG_ATTACK_LEN:  attack_len   = val & 32'hFFFFF;
      CFG_DECAY_LEN:   decay_len    = val & 32'hFFFFF;
      CFG_RELEASE_LEN: release_len  = val & 32'hFFFFF;
      CFG_SUSTAIN:     sustain_frac = val & 32'hFFFF;
      CFG_PEAK:        peak         = val & 32'hFFFF;
      CFG_NOISE_MIX:   noise_share  = val & 32'hFFFF;
      default: ;
    endcase
  endtask

  task automatic set_voice(int unsigned a, int unsigned d, int unsigned r,
                           int unsigned sus, int unsigned pk, int unsigned mix);
    settle();
    set_reg(CFG_ATTACK_LEN, a);
    set_reg(CFG_DECAY_LEN, d);
    set_reg(CFG_RELEASE_LEN, r);
    set_reg(CFG_SUSTAIN, sus);
    set_reg(CFG_PEAK, pk);
    set_reg(CFG_NOISE_MIX, mix);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Mostly whole notes with random content; the rest is scattered noise
  // beats and notes cut short or retriggered.
  task automatic random_notes(int n_items, int ramp);
    int start;
    start = note_queue.size();
    while (note_queue.size() - start < n_items) begin
      case ($urandom_range(0, 9))
        0: push(2'($urandom), 24'($urandom), 8'($urandom), 16'($urandom));
        1: push(MODE_TABLE_WR, 24'($urandom), 8'($urandom), 16'($urandom));
        2: begin
          push(MODE_NOTE_ON, 24'($urandom));
          ticks($urandom_range(0, ramp));
        end
        default: begin
          push(MODE_NOTE_ON, ($urandom_range(0, 1) == 0) ? 24'($urandom)
                                                          : 24'($urandom_range(0, 1 << 18)));
          ticks($urandom_range(0, 3 * ramp + 4));
          push(MODE_NOTE_OFF, 24'($urandom), 8'($urandom), 16'($urandom));
          ticks($urandom_range(0, 2 * ramp + 2));
        end
      endcase
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Fill the whole wavetable first so every phase reads a written entry.
    for (int i = 0; i < 256; i++)
      push(MODE_TABLE_WR, 24'($urandom), 8'(i),
           (i == 0) ? 16'h7FFF : (i == 1) ? 16'h8000 : 16'($urandom));
    settle();

    // Directed: idle tick, zero step, note off in attack, sustain and release,
    // retrigger, largest step, and idle ticks after the release ends.
    ticks(2);
    push(MODE_NOTE_ON, 24'd0);
    ticks(3);
    push(MODE_NOTE_OFF);
    push(MODE_NOTE_OFF);
    ticks(2);
    push(MODE_NOTE_ON, 24'hFFFFFF);
    push(MODE_NOTE_OFF);
    push(MODE_NOTE_ON, 24'hFFFFFF);
    ticks(4);
    push(MODE_TABLE_WR, '0, 8'hFF, 16'h8000);
    push(MODE_TABLE_WR, '0, 8'h00, 16'h7FFF);
    ticks(3);
    push(MODE_NOTE_OFF, 24'hFFFFFF, 8'hFF, 16'hFFFF);
    ticks(3);

    set_voice(3, 4, 5, 40000, 65535, 0);
    random_notes(150, 5);
    set_voice(1, 1, 1, 65535, 65535, 65535);
    random_notes(150, 2);
    quiet = 1'b1;
    set_voice(0, 0, 0, 0, 0, 30000);
    random_notes(100, 2);
    quiet = 1'b0;
    set_voice(10, 7, 12, 32768, 50000, 1000);
    random_notes(150, 12);

    // Longest ramps: few ticks, and leave the voice deep in an attack so the
    // shorter attack that follows sees a count beyond its length.
    set_voice(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20000, 65535, 20000);
    push(MODE_NOTE_ON, 24'h012345);
    ticks(10);
    push(MODE_NOTE_OFF);
    ticks(10);
    push(MODE_NOTE_ON, 24'h00F000);
    ticks(30);
    set_voice(5, 1048575, 3, 0, 65535, 65535);
    ticks(8);
    push(MODE_NOTE_OFF);
    ticks(2);
    set_voice(5, 5, 1, 65535, 40000, 0);
    ticks(3);

    repeat (4) begin
      set_voice($urandom_range(0, 16), $urandom_range(1, 16), $urandom_range(1, 16),
                $urandom_range(0, 65535), $urandom_range(0, 65535),
                ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 65535));
      quiet = ($urandom_range(0, 3) == 0);
      random_notes(140, 12);
    end

    settle();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
